// File: rtl/ttq_pkg.sv
// shared types and constants for the timed task queue
`timescale 1ns / 1ps
package ttq_pkg;
    localparam int READY_DEPTH_DEF = 64;
    localparam int TIMED_DEPTH_DEF = 64;
    localparam int TAG_W = 16;
    localparam int TIME_W = 32;
    localparam int CNT_W = 8;
    localparam int DROP_W = 32;

    localparam logic [2:0] MODE_POST_DELAY = 3'd0;
    localparam logic [2:0] MODE_POST_AT    = 3'd1;
    localparam logic [2:0] MODE_POLL       = 3'd2;
    localparam logic [2:0] MODE_STOP       = 3'd3;
    localparam logic [2:0] MODE_RESTART    = 3'd4;

    localparam logic [0:0] REG_MAX_ENTRIES = 1'd0;

    typedef struct packed {
        logic [2:0]        mode;
        logic              safe;
        logic [TAG_W-1:0]  task_tag;
        logic [TIME_W-1:0] time_value;
        logic [TIME_W-1:0] now;
    } t_in_word;

    typedef struct packed {
        logic              accepted;
        logic              dispatched;
        logic [TAG_W-1:0]  out_tag;
        logic              out_safe;
        logic [CNT_W-1:0]  unsafe_pending;
        logic [CNT_W-1:0]  safe_pending;
        logic [DROP_W-1:0] drop_total;
        logic              stopped;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } t_state;

    // per-cell timed entry, ties are ordered by position in the chain
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] due;
        logic [TAG_W-1:0]  tag;
        logic              safe;
    } t_timed_ent;
endpackage

// File: rtl/ttq_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module ttq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/ttq_cell.sv
// one cell of the sorted timed store chain
`timescale 1ns / 1ps
module ttq_cell
    import ttq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_first,
    input  logic       i_clear,
    input  logic       i_ins,
    input  logic       i_pop,
    input  t_timed_ent i_ins_ent,
    input  t_timed_ent i_left,
    input  t_timed_ent i_right,
    output t_timed_ent o_ent
);
    // chain kept sorted by due, equal due after older ones
    t_timed_ent r_ent;
    t_timed_ent n_ent;
    logic       w_left_gt;
    logic       w_me_gt;
    logic       w_take_new;

    assign w_left_gt  = i_left.valid && (i_left.due > i_ins_ent.due);
    assign w_me_gt    = !r_ent.valid || (r_ent.due > i_ins_ent.due);
    // new entry lands where the left neighbour stays put, empty cells beyond stay empty
    assign w_take_new = i_first || i_left.valid;
    assign o_ent      = r_ent;

    always_comb begin
        n_ent = r_ent;
        if (i_pop) begin
            n_ent = i_right;
        end else if (i_ins) begin
            if (w_me_gt) begin
                if (w_left_gt) begin
                    n_ent = i_left;
                end else if (w_take_new) begin
                    n_ent = i_ins_ent;
                end
            end
        end
        if (i_clear) begin
            n_ent.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
        end else begin
            r_ent.valid <= n_ent.valid;
        end
        r_ent.due  <= n_ent.due;
        r_ent.tag  <= n_ent.tag;
        r_ent.safe <= n_ent.safe;
    end
endmodule

// File: rtl/timed_task_queue.sv
// top level of the timed task queue
`timescale 1ns / 1ps
// timed task queue: a command goes in on start when busy is low and its single
// result word is registered on o_done for one cycle; a command passes through
// accept, execute with the ready fifo read, and report. the receiver cannot hold
// results off. timed posts sit in a chain of cells kept sorted by due time, so the
// earliest due entry is always cell zero; ties keep post order. the ready fifo is a
// ram with one registered read port. the user must write max_entries over the apb
// port only while idle; the block itself does not enforce it.
module timed_task_queue
    import ttq_pkg::*;
#(
    parameter int READY_DEPTH = READY_DEPTH_DEF,
    parameter int TIMED_DEPTH = TIMED_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_word,
    output logic      o_done,
    output t_out_word o_word,
    input  logic      psel,
    input  logic      penable,
    input  logic      pwrite,
    input  logic      paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic      pready
);
    localparam int RA_W = $clog2(READY_DEPTH);
    localparam int RC_W = $clog2(READY_DEPTH + 1);
    localparam int TC_W = $clog2(TIMED_DEPTH + 1);
    localparam int TS_W = RC_W + 1;
    localparam int CMAX_W = (RC_W > TC_W) ? RC_W : TC_W;
    localparam int SUM_W = ((CMAX_W > 8) ? CMAX_W : 8) + 1;

    t_state r_state, n_state;
    t_in_word r_in;
    logic [7:0] r_max;
    logic [RC_W-1:0] r_rcnt, n_rcnt;
    logic [RA_W-1:0] r_rhead, n_rhead;
    logic [TC_W-1:0] r_tcnt, n_tcnt;
    logic [CNT_W-1:0] r_unsafe, n_unsafe, r_safec, n_safec;
    logic [DROP_W-1:0] r_drop, n_drop;
    logic r_stop, n_stop;
    logic r_done, n_done;
    t_out_word r_out, n_out;

    // apb register
    assign pready = 1'b1;
    assign prdata = {24'd0, r_max};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
        end else if (psel && penable && pwrite && paddr == REG_MAX_ENTRIES) begin
            r_max <= pwdata[7:0];
        end
    end

    // ready fifo ram
    logic [RA_W-1:0] w_waddr;
    logic [TAG_W:0] w_wdata, w_rdata;
    logic w_we;
    ttq_ram #(.WIDTH(TAG_W + 1), .DEPTH(READY_DEPTH)) u_ready (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(r_rhead), .o_rdata(w_rdata)
    );

    // timed chain
    t_timed_ent w_ent [TIMED_DEPTH];
    logic w_ins, w_pop, w_clr;
    t_timed_ent w_new;
    t_timed_ent c_none;
    assign c_none = '0;

    for (genvar g = 0; g < TIMED_DEPTH; g++) begin : g_cell
        ttq_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_first(g == 0), .i_clear(w_clr),
            .i_ins(w_ins), .i_pop(w_pop), .i_ins_ent(w_new),
            .i_left(g == 0 ? c_none : w_ent[(g == 0) ? 0 : g-1]),
            .i_right(g == TIMED_DEPTH-1 ? c_none : w_ent[(g == TIMED_DEPTH-1) ? g : g+1]),
            .o_ent(w_ent[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rcnt <= '0; r_rhead <= '0; r_tcnt <= '0;
            r_unsafe <= '0; r_safec <= '0; r_drop <= '0; r_stop <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rcnt <= n_rcnt; r_rhead <= n_rhead; r_tcnt <= n_tcnt;
            r_unsafe <= n_unsafe; r_safec <= n_safec; r_drop <= n_drop;
            r_stop <= n_stop; r_done <= n_done;
        end
        if (start && !busy) r_in <= i_word;
        r_out <= n_out;
    end

    assign busy = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_word = r_out;

    // combinational execute
    logic w_is_post, w_to_ready, w_lim, w_ok, w_full, w_move, w_disp;
    logic [TIME_W:0] w_sum;
    logic [TIME_W-1:0] w_due;
    logic [SUM_W-1:0] w_occ;
    logic [TS_W-1:0] w_tsum;
    logic [RA_W-1:0] w_tail;
    logic [RC_W-1:0] w_rc2;
    logic w_osafe;
    logic [TAG_W-1:0] w_otag;

    always_comb begin
        n_state = r_state; n_rcnt = r_rcnt; n_rhead = r_rhead; n_tcnt = r_tcnt;
        n_unsafe = r_unsafe; n_safec = r_safec; n_drop = r_drop; n_stop = r_stop;
        n_done = 1'b0; n_out = r_out;
        w_we = 1'b0; w_waddr = '0; w_wdata = '0;
        w_ins = 1'b0; w_pop = 1'b0; w_clr = 1'b0;
        w_sum = {1'b0, r_in.now} + {1'b0, r_in.time_value};
        w_due = w_sum[TIME_W] ? '1 : w_sum[TIME_W-1:0];
        w_new.valid = 1'b1;
        w_new.due = (r_in.mode == MODE_POST_AT) ? r_in.time_value : w_due;
        w_new.tag = r_in.task_tag; w_new.safe = r_in.safe;
        w_is_post = (r_in.mode == MODE_POST_DELAY) || (r_in.mode == MODE_POST_AT);
        w_to_ready = (r_in.mode == MODE_POST_DELAY) && (r_in.time_value == '0);
        w_occ = SUM_W'(r_rcnt) + SUM_W'(r_tcnt);
        w_lim = !r_in.safe && (r_max != 8'd0) && (w_occ >= SUM_W'(r_max));
        w_full = w_to_ready ? (r_rcnt == RC_W'(READY_DEPTH))
                            : (r_tcnt == TC_W'(TIMED_DEPTH));
        w_ok = w_is_post && !w_lim && !w_full;
        // tail wraps at the fifo depth
        w_tsum = TS_W'(r_rhead) + TS_W'(r_rcnt);
        w_tail = (w_tsum >= TS_W'(READY_DEPTH)) ? RA_W'(w_tsum - TS_W'(READY_DEPTH))
                                                : RA_W'(w_tsum);
        w_move = (r_in.mode == MODE_POLL) && !r_stop && (r_tcnt != '0)
            && (r_rcnt != RC_W'(READY_DEPTH)) && (w_ent[0].due <= r_in.now);
        w_rc2 = r_rcnt + RC_W'(w_move);
        w_disp = (r_in.mode == MODE_POLL) && !r_stop && (w_rc2 != '0);
        // head from ram, unless the fifo was empty and the moved entry is the head
        w_otag = (r_rcnt == '0) ? w_ent[0].tag : w_rdata[TAG_W:1];
        w_osafe = (r_rcnt == '0) ? w_ent[0].safe : w_rdata[0];
        case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_DONE;
                n_out = '0;
                if (w_is_post) begin
                    if (w_ok) begin
                        if (w_to_ready) begin
                            w_we = 1'b1; w_waddr = w_tail;
                            w_wdata = {r_in.task_tag, r_in.safe};
                            n_rcnt = r_rcnt + 1'b1;
                        end else begin
                            w_ins = 1'b1; n_tcnt = r_tcnt + 1'b1;
                        end
                        if (r_in.safe) begin
                            if (r_safec != '1) n_safec = r_safec + 1'b1;
                        end else if (r_unsafe != '1) n_unsafe = r_unsafe + 1'b1;
                    end else if (r_drop != '1) begin
                        n_drop = r_drop + 1'b1;
                    end
                    n_out.accepted = w_ok;
                end else if (r_in.mode == MODE_POLL) begin
                    if (w_move) begin
                        w_pop = 1'b1; n_tcnt = r_tcnt - 1'b1;
                        w_we = 1'b1; w_waddr = w_tail;
                        w_wdata = {w_ent[0].tag, w_ent[0].safe};
                    end
                    if (w_disp) begin
                        n_out.dispatched = 1'b1;
                        n_out.out_tag = w_otag; n_out.out_safe = w_osafe;
                        n_rhead = (r_rhead == RA_W'(READY_DEPTH - 1)) ? '0
                                                                       : r_rhead + 1'b1;
                        n_rcnt = w_rc2 - 1'b1;
                        if (w_osafe) begin
                            if (r_safec != '0) n_safec = r_safec - 1'b1;
                        end else if (r_unsafe != '0) n_unsafe = r_unsafe - 1'b1;
                    end else begin
                        n_rcnt = w_rc2;
                    end
                end else if (r_in.mode == MODE_STOP) begin
                    if (!r_stop) begin
                        n_stop = 1'b1; n_drop = '0; n_rcnt = '0; n_rhead = '0;
                        n_tcnt = '0; n_unsafe = '0; n_safec = '0; w_clr = 1'b1;
                    end
                end else if (r_in.mode == MODE_RESTART) begin
                    n_drop = '0; n_stop = 1'b0;
                end
                n_out.unsafe_pending = n_unsafe;
                n_out.safe_pending = n_safec;
                n_out.drop_total = n_drop;
                n_out.stopped = n_stop;
                n_done = 1'b1;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// File: test/tb_top.sv
// self-checking testbench for the timed task queue
`timescale 1ns / 1ps
module tb_top;
    import ttq_pkg::*;

    localparam int RDEPTH = 64;
    localparam int TDEPTH = 64;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in_word    i_word = '0;
    logic        o_done;
    t_out_word   o_word;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic        paddr = 1'b0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    timed_task_queue u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_word(i_word), .o_done(o_done), .o_word(o_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 i_clk = ~i_clk;

    // scheduler shadow state
    logic [TAG_W-1:0]  rq_tag [RDEPTH];
    logic              rq_safe [RDEPTH];
    int                rq_count, rq_head;
    logic [TIME_W-1:0] tm_due [TDEPTH];
    logic [TAG_W-1:0]  tm_tag [TDEPTH];
    logic              tm_safe [TDEPTH];
    int                tm_count;
    int                unsafe_cnt, safe_cnt;
    logic [31:0]       drops;
    logic              halted;
    int                limit_val;

    t_out_word  pending_words [$];
    int         err_count = 0;
    int         cycles = 0;

    task automatic shadow_clear();
        rq_count = 0; rq_head = 0; tm_count = 0;
        unsafe_cnt = 0; safe_cnt = 0; drops = '0; halted = 1'b0; limit_val = 0;
    endtask

    function automatic void bump_drop();
        if (drops != 32'hFFFF_FFFF) drops = drops + 1;
    endfunction

    function automatic void rq_push(logic [TAG_W-1:0] tg, logic sf);
        int tail;
        tail = (rq_head + rq_count) % RDEPTH;
        rq_tag[tail] = tg;
        rq_safe[tail] = sf;
        rq_count++;
    endfunction

    function automatic logic try_post(logic to_ready, logic [TIME_W-1:0] due,
                                      logic [TAG_W-1:0] tg, logic sf);
        // limit counts both stores, safe entries included
        if (!sf && limit_val != 0 && rq_count + tm_count >= limit_val) begin
            bump_drop();
            return 1'b0;
        end
        if (to_ready) begin
            if (rq_count >= RDEPTH) begin
                bump_drop();
                return 1'b0;
            end
            rq_push(tg, sf);
        end else begin
            if (tm_count >= TDEPTH) begin
                bump_drop();
                return 1'b0;
            end
            tm_due[tm_count] = due;
            tm_tag[tm_count] = tg;
            tm_safe[tm_count] = sf;
            tm_count++;
        end
        if (sf) begin
            if (safe_cnt < 255) safe_cnt++;
        end else begin
            if (unsafe_cnt < 255) unsafe_cnt++;
        end
        return 1'b1;
    endfunction

    // earliest due entry, once due and with fifo room, moves to the fifo tail, first posted wins ties
    function automatic void promote_due(logic [TIME_W-1:0] tnow);
        int best;
        if (tm_count == 0 || rq_count >= RDEPTH) return;
        best = 0;
        for (int i = 1; i < tm_count; i++)
            if (tm_due[i] < tm_due[best]) best = i;
        if (tm_due[best] > tnow) return;
        rq_push(tm_tag[best], tm_safe[best]);
        for (int i = best; i + 1 < tm_count; i++) begin
            tm_due[i] = tm_due[i+1];
            tm_tag[i] = tm_tag[i+1];
            tm_safe[i] = tm_safe[i+1];
        end
        tm_count--;
    endfunction

    function automatic t_out_word schedule_step(t_in_word w);
        t_out_word  r;
        logic [32:0] sum;
        r = '0;
        case (w.mode)
            MODE_POST_DELAY: begin
                if (w.time_value == 0) begin
                    r.accepted = try_post(1'b1, '0, w.task_tag, w.safe);
                end else begin
                    // due time saturates on overflow
                    sum = {1'b0, w.now} + {1'b0, w.time_value};
                    r.accepted = try_post(1'b0, sum[32] ? '1 : sum[31:0],
                                          w.task_tag, w.safe);
                end
            end
            MODE_POST_AT: r.accepted = try_post(1'b0, w.time_value, w.task_tag, w.safe);
            MODE_POLL: begin
                if (!halted) begin
                    promote_due(w.now);
                    if (rq_count > 0) begin
                        r.dispatched = 1'b1;
                        r.out_tag = rq_tag[rq_head];
                        r.out_safe = rq_safe[rq_head];
                        rq_head = (rq_head + 1) % RDEPTH;
                        rq_count--;
                        if (r.out_safe) begin
                            if (safe_cnt > 0) safe_cnt--;
                        end else begin
                            if (unsafe_cnt > 0) unsafe_cnt--;
                        end
                    end
                end
            end
            MODE_STOP: begin
                if (!halted) begin
                    halted = 1'b1; drops = '0; rq_count = 0; rq_head = 0;
                    tm_count = 0; unsafe_cnt = 0; safe_cnt = 0;
                end
            end
            MODE_RESTART: begin
                drops = '0;
                halted = 1'b0;
            end
            default: ;
        endcase
        r.unsafe_pending = unsafe_cnt[CNT_W-1:0];
        r.safe_pending = safe_cnt[CNT_W-1:0];
        r.drop_total = drops;
        r.stopped = halted;
        return r;
    endfunction

    // result checker, sampled at the rising edge
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_done) begin
            if (pending_words.size() == 0) begin
                $error("result word with nothing expected");
                err_count++;
            end else begin
                t_out_word e;
                e = pending_words.pop_front();
                if (o_word.accepted !== e.accepted) begin
                    $error("accepted exp %0h got %0h", e.accepted, o_word.accepted);
                    err_count++;
                end
                if (o_word.dispatched !== e.dispatched) begin
                    $error("dispatched exp %0h got %0h", e.dispatched, o_word.dispatched);
                    err_count++;
                end
                if (o_word.out_tag !== e.out_tag) begin
                    $error("out_tag exp %0h got %0h", e.out_tag, o_word.out_tag);
                    err_count++;
                end
                if (o_word.out_safe !== e.out_safe) begin
                    $error("out_safe exp %0h got %0h", e.out_safe, o_word.out_safe);
                    err_count++;
                end
                if (o_word.unsafe_pending !== e.unsafe_pending) begin
                    $error("unsafe_pending exp %0h got %0h", e.unsafe_pending,
                           o_word.unsafe_pending);
                    err_count++;
                end
                if (o_word.safe_pending !== e.safe_pending) begin
                    $error("safe_pending exp %0h got %0h", e.safe_pending,
                           o_word.safe_pending);
                    err_count++;
                end
                if (o_word.drop_total !== e.drop_total) begin
                    $error("drop_total exp %0h got %0h", e.drop_total, o_word.drop_total);
                    err_count++;
                end
                if (o_word.stopped !== e.stopped) begin
                    $error("stopped exp %0h got %0h", e.stopped, o_word.stopped);
                    err_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // apb write of the limit register, only while idle
    task automatic write_limit(int val);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = REG_MAX_ENTRIES; pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        limit_val = val;
    endtask

    task automatic drain();
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // one command word, held until it is taken; a directed expectation may be given
    task automatic send_word(t_in_word w, int gap, logic has_fixed, t_out_word fixed);
        t_out_word p;
        repeat (gap) @(negedge i_clk);
        @(negedge i_clk);
        i_word = w;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        p = schedule_step(w);
        pending_words.push_back(has_fixed ? fixed : p);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    function automatic t_in_word mk(logic [2:0] m, logic sf, logic [15:0] tg,
                                   logic [31:0] tv, logic [31:0] tn);
        t_in_word w;
        w.mode = m; w.safe = sf; w.task_tag = tg; w.time_value = tv; w.now = tn;
        return w;
    endfunction

    function automatic t_out_word st(logic acc, logic dsp, logic [15:0] tg, logic sf,
                                    int un, int sn, int dr, logic hl);
        t_out_word r;
        r.accepted = acc; r.dispatched = dsp; r.out_tag = tg; r.out_safe = sf;
        r.unsafe_pending = CNT_W'(un); r.safe_pending = CNT_W'(sn);
        r.drop_total = DROP_W'(dr); r.stopped = hl;
        return r;
    endfunction

    typedef struct {
        t_in_word  w;
        logic      fixed;
        t_out_word r;
    } t_row;

    t_row rows [$];

    task automatic random_burst(int n, int flavour);
        t_in_word w;
        int gap, pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            w.safe = 1'($urandom_range(0, 1));
            w.task_tag = 16'($urandom);
            w.now = (flavour == 0) ? $urandom_range(0, 2000) : $urandom;
            w.time_value = ($urandom_range(0, 3) == 0) ? 32'd0 :
                           (flavour == 0) ? $urandom_range(0, 800) : $urandom;
            if (pick < 35) w.mode = MODE_POST_DELAY;
            else if (pick < 50) w.mode = MODE_POST_AT;
            else if (pick < 92) w.mode = MODE_POLL;
            else if (pick < 95) w.mode = MODE_STOP;
            else if (pick < 98) w.mode = MODE_RESTART;
            else w.mode = 3'($urandom_range(5, 7));
            // back-to-back stretches alternate with gapped ones
            gap = (k % 60 < 20) ? 0 : $urandom_range(0, 18);
            send_word(w, gap, 1'b0, '0);
        end
    endtask

    initial begin
        shadow_clear();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table: after reset, unknown mode, extremes, stop and restart
        rows.push_back('{mk(3'd5, 1'b0, 16'h0, 32'h0, 32'h0), 1'b1,
                         st(0, 0, 0, 0, 0, 0, 0, 0)});
        rows.push_back('{mk(MODE_POLL, 1'b0, 16'h0, 32'h0, 32'h0), 1'b1,
                         st(0, 0, 0, 0, 0, 0, 0, 0)});
        rows.push_back('{mk(MODE_POST_DELAY, 1'b0, 16'hFFFF, 32'h0, 32'h0), 1'b1,
                         st(1, 0, 0, 0, 1, 0, 0, 0)});
        rows.push_back('{mk(MODE_POST_DELAY, 1'b1, 16'h0001, 32'h0, 32'h0), 1'b1,
                         st(1, 0, 0, 0, 1, 1, 0, 0)});
        rows.push_back('{mk(MODE_POLL, 1'b0, 16'h0, 32'h0, 32'h0), 1'b1,
                         st(0, 1, 16'hFFFF, 0, 0, 1, 0, 0)});
        // due time overflow saturates
        rows.push_back('{mk(MODE_POST_DELAY, 1'b0, 16'h00AA, 32'hFFFF_FFFF,
                            32'hFFFF_FFF0), 1'b0, '0});
        // absolute time in the past is due at once
        rows.push_back('{mk(MODE_POST_AT, 1'b1, 16'h0055, 32'h10, 32'h1000), 1'b0, '0});
        rows.push_back('{mk(MODE_POST_AT, 1'b0, 16'h0056, 32'h10, 32'h1000), 1'b0, '0});
        rows.push_back('{mk(MODE_POLL, 1'b0, 16'h0, 32'h0, 32'h1000), 1'b0, '0});
        rows.push_back('{mk(MODE_POLL, 1'b0, 16'h0, 32'h0, 32'h1000), 1'b0, '0});
        rows.push_back('{mk(MODE_POLL, 1'b1, 16'h0, 32'h0, 32'hFFFF_FFFF), 1'b0, '0});
        rows.push_back('{mk(MODE_POLL, 1'b0, 16'h0, 32'h0, 32'hFFFF_FFFF), 1'b0, '0});
        rows.push_back('{mk(MODE_POLL, 1'b0, 16'h0, 32'h0, 32'hFFFF_FFFF), 1'b0, '0});
        // posting while stopped, stop twice, then restart
        rows.push_back('{mk(MODE_STOP, 1'b0, 16'h0, 32'h0, 32'h0), 1'b1,
                         st(0, 0, 0, 0, 0, 0, 0, 1)});
        rows.push_back('{mk(MODE_STOP, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                         1'b1, st(0, 0, 0, 0, 0, 0, 0, 1)});
        rows.push_back('{mk(MODE_POST_DELAY, 1'b1, 16'h1234, 32'h0, 32'h0), 1'b1,
                         st(1, 0, 0, 0, 0, 1, 0, 1)});
        rows.push_back('{mk(MODE_POLL, 1'b0, 16'h0, 32'h0, 32'h0), 1'b1,
                         st(0, 0, 0, 0, 0, 1, 0, 1)});
        rows.push_back('{mk(MODE_RESTART, 1'b0, 16'h0, 32'h0, 32'h0), 1'b1,
                         st(0, 0, 0, 0, 0, 1, 0, 0)});
        rows.push_back('{mk(MODE_POLL, 1'b0, 16'h0, 32'h0, 32'h0), 1'b1,
                         st(0, 1, 16'h1234, 1, 0, 0, 0, 0)});
        rows.push_back('{mk(3'd7, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1,
                         st(0, 0, 0, 0, 0, 0, 0, 0)});
        foreach (rows[i]) send_word(rows[i].w, $urandom_range(0, 3), rows[i].fixed,
                                    rows[i].r);
        drain();

        // limit of one: second unsafe post refused, safe one bypasses
        write_limit(1);
        send_word(mk(MODE_POST_DELAY, 1'b0, 16'h0A, 32'h0, 32'h0), 0, 1'b1,
                  st(1, 0, 0, 0, 1, 0, 0, 0));
        send_word(mk(MODE_POST_DELAY, 1'b0, 16'h0B, 32'h0, 32'h0), 0, 1'b1,
                  st(0, 0, 0, 0, 1, 0, 1, 0));
        send_word(mk(MODE_POST_AT, 1'b1, 16'h0C, 32'h5, 32'h0), 0, 1'b0, '0);
        send_word(mk(MODE_STOP, 1'b0, 16'h0, 32'h0, 32'h0), 0, 1'b0, '0);
        send_word(mk(MODE_RESTART, 1'b0, 16'h0, 32'h0, 32'h0), 0, 1'b0, '0);
        drain();

        // store full: fill the fifo and the timed store with no limit
        write_limit(0);
        for (int k = 0; k < 66; k++)
            send_word(mk(MODE_POST_DELAY, k[0], 16'(k), 32'h0, 32'h0), 0, 1'b0, '0);
        for (int k = 0; k < 66; k++)
            send_word(mk(MODE_POST_AT, k[1], 16'(k + 100), 32'($urandom_range(0, 9)),
                         32'h0), 0, 1'b0, '0);
        // polls with the fifo full keep due entries where they are
        for (int k = 0; k < 100; k++)
            send_word(mk(MODE_POLL, 1'b0, 16'h0, 32'h0, 32'd20), k % 3, 1'b0, '0);
        drain();

        // random phases at several limits, the extremes among them
        write_limit(128);
        random_burst(60, 0);
        drain();
        write_limit($urandom_range(2, 12));
        random_burst(50, 0);
        // sender holds off until every result is in
        drain();
        write_limit(0);
        random_burst(50, 1);
        drain();
        write_limit(1);
        random_burst(30, 0);
        drain();

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/ttq_pkg.sv
rtl/ttq_ram.sv
rtl/ttq_cell.sv
rtl/timed_task_queue.sv
test/tb_top.sv
